// File: rtl/slfr_pkg.sv
// slfr_pkg: shared constants for the sync/length framed byte receiver
// used by sync_length_frame_receiver and its port checker; no dependencies
package slfr_pkg;

	// framing constants
	localparam logic [7:0] SYNC_BYTE      = 8'hFE;
	localparam logic [8:0] LENGTH_OFFSET  = 9'd5;
	localparam logic [8:0] FRAME_OVERHEAD = 9'd7;

	// field widths
	localparam int BYTE_W   = 8;
	localparam int OFFSET_W = 9;
	localparam int TDATA_W  = 24;
	localparam int TUSER_W  = 2;

	// configuration register byte addresses
	localparam int          ADDR_W         = 3;
	localparam logic [2:0]  REG_ACCEPT_ALL = 3'd0;
	localparam logic [2:0]  REG_WATCHED    = 3'd4;

endpackage

// File: rtl/sync_length_frame_receiver.sv
// sync_length_frame_receiver: hunts for a sync byte, frames by length byte,
// checks the inverted-sum checksum and the node filter; depends on slfr_pkg
//
// One received byte is accepted per clock while s_axis_tready is high: a
// byte goes through an input register, the combinational framing logic
// and a result register, which drives m_axis_tvalid for each frame byte.
// s_axis_tready drops only while the result register is full, the input
// register is occupied and the downstream side stalls. Bytes outside a
// frame other than 0xFE are dropped.
// On the final byte (offset L+6, L being frame byte 5) tlast is set and
// tuser reports the checksum and node filter results.
module sync_length_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// input bytes
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	// frame bytes
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] frame_byte, [16:8] byte_offset, [23:17] zero
	output logic        m_axis_tlast,   // last_byte
	output logic [1:0]  m_axis_tuser,   // [0] check_good, [1] node_selected
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	logic       accept_all_q;
	logic [7:0] watched_node_q;

	// framing state
	logic       in_frame_q;
	logic [8:0] position_q;
	logic [7:0] payload_len_q;
	logic [7:0] running_sum_q;
	logic       node_hit_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [8:0] out_offset_q;
	logic       out_last_q;
	logic       out_good_q;
	logic       out_sel_q;

	logic advance;
	logic cfg_write;

	// per-byte framing results
	logic       emit;
	logic [8:0] offset;
	logic       is_last;
	logic       good;
	logic       sel;
	logic       in_frame_d;
	logic [8:0] position_d;
	logic [7:0] payload_len_d;
	logic [7:0] running_sum_d;
	logic       node_hit_d;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign pready        = 1'b1;
	assign cfg_write     = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_all_q   <= 1'b1;
			watched_node_q <= 8'd0;
		end else if (cfg_write) begin
			case (paddr)
				slfr_pkg::REG_ACCEPT_ALL: accept_all_q   <= pwdata[0];
				slfr_pkg::REG_WATCHED:    watched_node_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (paddr)
			slfr_pkg::REG_ACCEPT_ALL: prdata = {31'd0, accept_all_q};
			slfr_pkg::REG_WATCHED:    prdata = {24'd0, watched_node_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// framing logic for the byte in the input register
	always_comb begin
		emit          = 1'b0;
		offset        = position_q;
		is_last       = 1'b0;
		good          = 1'b0;
		sel           = 1'b0;
		in_frame_d    = in_frame_q;
		position_d    = position_q;
		payload_len_d = payload_len_q;
		running_sum_d = running_sum_q;
		node_hit_d    = node_hit_q;
		if (!in_frame_q) begin
			// hunting: only the sync byte opens a frame
			if (byte_s1 == slfr_pkg::SYNC_BYTE) begin
				emit          = 1'b1;
				offset        = 9'd0;
				in_frame_d    = 1'b1;
				position_d    = 9'd1;
				payload_len_d = 8'd0;
				running_sum_d = byte_s1;
				node_hit_d    = 1'b0;
			end
		end else begin
			emit = 1'b1;
			if (position_q == slfr_pkg::LENGTH_OFFSET) begin
				payload_len_d = byte_s1;
			end
			if ((position_q == 9'd1 || position_q == 9'd2) && byte_s1 == watched_node_q) begin
				node_hit_d = 1'b1;
			end
			is_last = (position_q > slfr_pkg::LENGTH_OFFSET) &&
				(position_q == ({1'b0, payload_len_q} + slfr_pkg::FRAME_OVERHEAD - 9'd1));
			if (is_last) begin
				good          = (byte_s1 == ~running_sum_q);
				sel           = accept_all_q || node_hit_q;
				in_frame_d    = 1'b0;
				position_d    = 9'd0;
				running_sum_d = 8'd0;
				node_hit_d    = 1'b0;
			end else begin
				running_sum_d = running_sum_q + byte_s1;
				position_d    = position_q + 9'd1;
			end
		end
	end

	// framing state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			position_q    <= 9'd0;
			payload_len_q <= 8'd0;
			running_sum_q <= 8'd0;
			node_hit_q    <= 1'b0;
		end else if (valid_s1 && advance) begin
			in_frame_q    <= in_frame_d;
			position_q    <= position_d;
			payload_len_q <= payload_len_d;
			running_sum_q <= running_sum_d;
			node_hit_q    <= node_hit_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			out_byte_q   <= byte_s1;
			out_offset_q <= offset;
			out_last_q   <= is_last;
			out_good_q   <= good;
			out_sel_q    <= sel;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_offset_q, out_byte_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = {out_sel_q, out_good_q};

endmodule

// File: rtl/slfr_checker.sv
// slfr_checker: port-level checks for sync_length_frame_receiver
// depends on slfr_pkg; bound to the top level at the end of this file
module slfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [1:0]  m_axis_tuser
);

	// a stalled result request holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
	else $error("stalled result request changed");

	// offset zero is always the sync byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[16:8] == 9'd0 |->
			m_axis_tdata[7:0] == slfr_pkg::SYNC_BYTE && !m_axis_tlast)
	else $error("frame start is not a sync byte");

	// status flags only on the final byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == 2'b00)
	else $error("status flags on a non-final byte");

	// a frame ends no earlier than just past the length byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
			m_axis_tdata[16:8] > slfr_pkg::LENGTH_OFFSET && m_axis_tdata[23:17] == 7'd0)
	else $error("final byte at an impossible offset");

endmodule

bind sync_length_frame_receiver slfr_checker u_slfr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

// File: sim/tb_sync_length_frame_receiver.sv
// tb_sync_length_frame_receiver: self-checking bench for the sync/length framed byte receiver
// scripted byte and register requests, then random frames checked against a predictor
// depends on slfr_pkg and rtl/sync_length_frame_receiver.sv
module tb_sync_length_frame_receiver;

	// one predicted frame byte, as seen on the master side
	typedef struct packed {
		logic [7:0] data;
		logic [8:0] offset;
		logic       last;
		logic       good;
		logic       sel;
	} frame_out_t;

	// scripted request kinds: dropped byte, sync byte, frame byte, register write
	typedef enum logic [1:0] {ROW_DROP, ROW_SYNC, ROW_DATA, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  addr;
		logic [31:0] value;
	} script_row_t;

	localparam int SCRIPT_LEN   = 26;
	localparam int PHASES       = 5;
	localparam int PHASE_ITEMS  = 35;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES  = 400;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // [7:0] frame_byte, [16:8] byte_offset, [23:17] zero
	logic        m_axis_tlast;   // last_byte
	logic [1:0]  m_axis_tuser;   // [0] check_good, [1] node_selected
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// predictor copy of the registers and the framing state
	logic       pass_all;
	logic [7:0] node_addr;
	logic       framing;
	logic [8:0] next_offset;
	logic [7:0] frame_len;
	logic [7:0] byte_sum;
	logic       node_seen;

	frame_out_t pending_bytes[$];
	int         errors;
	int         fed_items;
	bit         steady_tx;
	bit         steady_rx;
	bit         hold_req;

	// directed script: three frames, with register writes in the middle of the second
	script_row_t script [SCRIPT_LEN] = '{
		// bytes while hunting are dropped
		'{ROW_DROP,  3'd0,           32'h00},
		'{ROW_DROP,  3'd0,           32'hFF},
		// frame with zero length, sync value as data, good checksum
		'{ROW_SYNC,  3'd0,           32'hFE},
		'{ROW_DATA,  3'd0,           32'hFE},
		'{ROW_DATA,  3'd0,           32'h00},
		'{ROW_DATA,  3'd0,           32'h80},
		'{ROW_DATA,  3'd0,           32'h01},
		'{ROW_DATA,  3'd0,           32'h00},
		'{ROW_DATA,  3'd0,           32'h82},
		// node address changed between bytes 1 and 2, filter on before the end
		'{ROW_SYNC,  3'd0,           32'hFE},
		'{ROW_DATA,  3'd0,           32'h11},
		'{ROW_WRITE, slfr_pkg::REG_WATCHED,    32'hFFFF_FF22},
		'{ROW_DATA,  3'd0,           32'h22},
		'{ROW_WRITE, slfr_pkg::REG_ACCEPT_ALL, 32'hFFFF_FFFE},
		'{ROW_DATA,  3'd0,           32'h33},
		'{ROW_DATA,  3'd0,           32'h44},
		'{ROW_DATA,  3'd0,           32'h01},
		'{ROW_DATA,  3'd0,           32'hFF},
		// failed checksum still closes the frame
		'{ROW_DATA,  3'd0,           32'h00},
		// filter on, no node match, good checksum
		'{ROW_SYNC,  3'd0,           32'hFE},
		'{ROW_DATA,  3'd0,           32'h00},
		'{ROW_DATA,  3'd0,           32'h01},
		'{ROW_DATA,  3'd0,           32'h02},
		'{ROW_DATA,  3'd0,           32'h03},
		'{ROW_DATA,  3'd0,           32'h00},
		'{ROW_DATA,  3'd0,           32'hFB}
	};

	sync_length_frame_receiver dut (.*);

	always #5 clk = ~clk;

	// predictor: advances the framing state by one accepted byte
	function automatic bit frame_step(input logic [7:0] b, output frame_out_t r);
		logic [8:0] off;
		r = '0;
		if (!framing) begin
			if (b != slfr_pkg::SYNC_BYTE)
				return 1'b0;
			framing     = 1'b1;
			next_offset = 9'd1;
			frame_len   = 8'd0;
			byte_sum    = b;
			node_seen   = 1'b0;
			r.data      = b;
			return 1'b1;
		end
		off = next_offset;
		if (off == slfr_pkg::LENGTH_OFFSET)
			frame_len = b;
		if ((off == 9'd1 || off == 9'd2) && b == node_addr)
			node_seen = 1'b1;
		r.data   = b;
		r.offset = off;
		if (off > slfr_pkg::LENGTH_OFFSET &&
				off == {1'b0, frame_len} + slfr_pkg::FRAME_OVERHEAD - 9'd1) begin
			r.last      = 1'b1;
			r.good      = (b == ~byte_sum);
			r.sel       = pass_all | node_seen;
			framing     = 1'b0;
			next_offset = 9'd0;
			byte_sum    = 8'd0;
			node_seen   = 1'b0;
		end else begin
			byte_sum    = byte_sum + b;
			next_offset = off + 9'd1;
		end
		return 1'b1;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int idle_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// payload length: mostly short frames
	function automatic int pick_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(0, 8);
		return $urandom_range(9, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
	endtask

	// offer one byte request, wait for acceptance, run the predictor
	task automatic push_byte(input logic [7:0] b, output bit got, output frame_out_t r);
		int gap;
		gap = steady_tx ? 0 : idle_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		got = frame_step(b, r);
	endtask

	task automatic feed_byte(input logic [7:0] b);
		bit         got;
		frame_out_t r;
		push_byte(b, got, r);
		if (got) begin
			pending_bytes.push_back(r);
			fed_items++;
		end
	endtask

	// stop sending until every predicted byte has come out
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write on an idle block, then read back
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
		logic [31:0] want;
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == slfr_pkg::REG_ACCEPT_ALL)
			pass_all = value[0];
		else
			node_addr = value[7:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		want = (addr == slfr_pkg::REG_ACCEPT_ALL) ? {31'd0, pass_all} : {24'd0, node_addr};
		if (prdata !== want)
			report_mismatch("register readback", prdata, want);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// one well-formed frame, maybe behind line noise, checksum sometimes broken
	task automatic send_frame(input int len);
		logic [7:0] sum;
		logic [7:0] b;
		logic [7:0] chk;
		int         junk;
		junk = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
		repeat (junk) begin
			b = 8'($urandom);
			if (b == slfr_pkg::SYNC_BYTE)
				b = 8'h00;
			feed_byte(b);
		end
		sum = slfr_pkg::SYNC_BYTE;
		feed_byte(slfr_pkg::SYNC_BYTE);
		for (int off = 1; off < len + slfr_pkg::FRAME_OVERHEAD - 1; off++) begin
			if (off <= 2 && $urandom_range(0, 2) == 0)
				b = node_addr;
			else if (off == slfr_pkg::LENGTH_OFFSET)
				b = len[7:0];
			else
				b = 8'($urandom);
			sum = sum + b;
			feed_byte(b);
		end
		chk = ~sum;
		if ($urandom_range(0, 7) == 0)
			chk = chk ^ 8'($urandom_range(1, 255));
		feed_byte(chk);
	endtask

	// receiver side: random stalls, plus one long hold-off on request
	initial begin : sink_ctrl
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!steady_rx && $urandom_range(0, 3) == 0)
					stall_left = idle_gap();
			end
		end
	end

	// compare each frame byte with the oldest prediction
	always @(posedge clk) begin : out_check
		frame_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch("frame byte with nothing pending", 32'(m_axis_tdata), 32'd0);
			end else begin
				want = pending_bytes.pop_front();
				if (m_axis_tdata[7:0] !== want.data)
					report_mismatch("frame_byte", 32'(m_axis_tdata[7:0]), 32'(want.data));
				if (m_axis_tdata[16:8] !== want.offset)
					report_mismatch("byte_offset", 32'(m_axis_tdata[16:8]),
						32'(want.offset));
				if (m_axis_tdata[23:17] !== 7'd0)
					report_mismatch("tdata padding", 32'(m_axis_tdata[23:17]), 32'd0);
				if (m_axis_tlast !== want.last)
					report_mismatch("last_byte", 32'(m_axis_tlast), 32'(want.last));
				if (m_axis_tuser[0] !== want.good)
					report_mismatch("check_good", 32'(m_axis_tuser[0]), 32'(want.good));
				if (m_axis_tuser[1] !== want.sel)
					report_mismatch("node_selected", 32'(m_axis_tuser[1]), 32'(want.sel));
			end
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("tb_sync_length_frame_receiver failed");
		$finish;
	end

	initial begin
		bit         got;
		frame_out_t r;
		int         phase_start;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'd0;
		m_axis_tready = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = 3'd0;
		pwdata        = 32'd0;
		errors        = 0;
		fed_items     = 0;
		steady_tx     = 1'b0;
		steady_rx     = 1'b0;
		hold_req      = 1'b0;
		pass_all      = 1'b1;
		node_addr     = 8'd0;
		framing       = 1'b0;
		next_offset   = 9'd0;
		frame_len     = 8'd0;
		byte_sum      = 8'd0;
		node_seen     = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed script
		for (int i = 0; i < SCRIPT_LEN; i++) begin
			case (script[i].kind)
				ROW_WRITE: reg_write(script[i].addr, script[i].value);
				ROW_DROP: push_byte(script[i].value[7:0], got, r);
				ROW_SYNC: begin
					push_byte(script[i].value[7:0], got, r);
					pending_bytes.push_back(frame_out_t'{slfr_pkg::SYNC_BYTE, 9'd0,
						1'b0, 1'b0, 1'b0});
				end
				default: feed_byte(script[i].value[7:0]);
			endcase
		end

		// random frames under several register settings
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					reg_write(slfr_pkg::REG_ACCEPT_ALL, ($urandom() & ~32'h1) | 32'h0);
					reg_write(slfr_pkg::REG_WATCHED, ($urandom() & ~32'hFF) | 32'h00);
				end
				1: reg_write(slfr_pkg::REG_WATCHED, ($urandom() & ~32'hFF) | 32'hFF);
				2: begin
					reg_write(slfr_pkg::REG_ACCEPT_ALL, ($urandom() & ~32'h1) | 32'h1);
					reg_write(slfr_pkg::REG_WATCHED, $urandom());
				end
				3: begin
					reg_write(slfr_pkg::REG_ACCEPT_ALL, ($urandom() & ~32'h1) | 32'h0);
					reg_write(slfr_pkg::REG_WATCHED, $urandom());
				end
				default: begin
					reg_write(slfr_pkg::REG_ACCEPT_ALL, ($urandom() & ~32'h1) | 32'h1);
					reg_write(slfr_pkg::REG_WATCHED, ($urandom() & ~32'hFF) | 32'hFF);
				end
			endcase
			// phase 2 runs without gaps and carries the longest frame,
			// phase 3 keeps offering while the receiver holds off
			steady_tx = (p == 2 || p == 3);
			steady_rx = (p == 2);
			if (p == 3)
				hold_req = 1'b1;
			phase_start = fed_items;
			if (p == 2)
				send_frame(255);
			while (fed_items - phase_start < PHASE_ITEMS)
				send_frame(pick_len());
		end

		settle();
		if (errors == 0)
			$display("tb_sync_length_frame_receiver passed");
		else
			$display("tb_sync_length_frame_receiver failed");
		$finish;
	end

endmodule
